[src/matrix_multiply_4x4_macros.svh]
// Assertion macros used by the file that checks the matrix multiplier.
`ifndef MATRIX_MULTIPLY_4X4_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM4_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MM4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/mm4_pkg.sv]
package mm4_pkg;

    // Matrix geometry.
    localparam int MAT_N     = 4;
    localparam int MAT_ELEMS = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int STEP_W    = 6;

    localparam logic [CNT_W-1:0]  LAST_LOAD = 5'd31;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;
    localparam logic [IDX_W-1:0]  LAST_IDX  = 4'd15;
    localparam logic [1:0]        LAST_K    = 2'd3;

    // Sideband that travels with each multiply-accumulate step.
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             klast;
        logic [IDX_W-1:0] idx;
    } tag_t;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

[src/mm4_mac.sv]
module mm4_mac #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mm4_pkg::tag_t                 tag_in,
    input  logic signed [DATA_WIDTH-1:0]  a_data,
    input  logic signed [DATA_WIDTH-1:0]  b_data,
    output logic                          res_valid,
    output logic [31:0]                   res_value,
    output logic [mm4_pkg::IDX_W-1:0]     res_idx
);
    import mm4_pkg::*;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam int HI_W   = ACC_W - DATA_WIDTH + 1;

    tag_t                     tag_s2_reg;
    tag_t                     tag_s3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  shifted;
    logic [HI_W-1:0]          hi_bits;
    logic signed [DATA_WIDTH-1:0] sat_value;
    logic                     res_valid_reg;
    logic [31:0]              res_value_reg;
    logic [IDX_W-1:0]         res_idx_reg;

    // Stage 2: one signed multiply, registered.
    assign prod_next = PROD_W'(a_data) * PROD_W'(b_data);

    // Stage 3: the running sum restarts on the first term of each element.
    assign acc_next = (tag_s2_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);

    // Stage 4: truncate toward minus infinity, then clamp to the data range.
    assign shifted = acc_reg >>> FRAC_BITS;
    assign hi_bits = shifted[ACC_W-1:DATA_WIDTH-1];

    always_comb
    begin
        sat_value = shifted[DATA_WIDTH-1:0];
        if (shifted[ACC_W-1] && !(&hi_bits)) begin
            sat_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else if (!shifted[ACC_W-1] && (|hi_bits)) begin
            sat_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tag_s2_reg    <= '0;
            tag_s3_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            tag_s2_reg    <= tag_in;
            tag_s3_reg    <= tag_s2_reg;
            res_valid_reg <= tag_s3_reg.vld && tag_s3_reg.klast;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (tag_s2_reg.vld) begin
            acc_reg <= acc_next;
        end
        if (tag_s3_reg.vld && tag_s3_reg.klast) begin
            res_value_reg <= 32'(sat_value);
            res_idx_reg   <= tag_s3_reg.idx;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_value = res_value_reg;
    assign res_idx   = res_idx_reg;

endmodule

[src/matrix_multiply_4x4.sv]
// Loading takes one element per cycle; start is taken whenever busy is low.
// After the transfer of the 32nd element the block is busy until the last result:
// each result leaves through the read, multiply, accumulate and saturate registers.
// A run handles 32 elements and is paced by the single multiply-accumulate unit,
// which handles 64 steps per run; no new element is taken until the run ends.
// rst_n clears the load count and the sequencer; the receiver cannot stall.
`include "matrix_multiply_4x4_macros.svh"

module matrix_multiply_4x4 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] element_value,
    output logic               result_valid,
    output logic signed [31:0] product_value,
    output logic [1:0]         row_index,
    output logic [1:0]         col_index,
    output logic               last_result
);
    import mm4_pkg::*;

    // The two operand matrices live in small synchronous memories. Each has
    // one write port, used while loading, and one read port with registered
    // data, used while the products are formed.
    logic [DATA_WIDTH-1:0] a_mem [MAT_ELEMS];
    logic [DATA_WIDTH-1:0] b_mem [MAT_ELEMS];

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  load_count_reg;
    logic [CNT_W-1:0]  load_count_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    tag_t              tag_issue;
    tag_t              tag_s1_reg;
    logic [DATA_WIDTH-1:0] a_q_reg;
    logic [DATA_WIDTH-1:0] b_q_reg;
    logic              load_xfer;
    logic [1:0]        step_row;
    logic [1:0]        step_col;
    logic [1:0]        step_k;
    logic [IDX_W-1:0]  a_rd_addr;
    logic [IDX_W-1:0]  b_rd_addr;
    logic              mac_valid;
    logic [31:0]       mac_value;
    logic [IDX_W-1:0]  mac_idx;

    // An element transfer happens only while the sequencer is in its load state.
    assign busy      = (state_reg != ST_LOAD);
    assign load_xfer = start && !busy;

    // The step counter walks row, column and inner index, inner index fastest.
    assign step_row  = step_reg[5:4];
    assign step_col  = step_reg[3:2];
    assign step_k    = step_reg[1:0];
    assign a_rd_addr = {step_row, step_k};
    assign b_rd_addr = {step_k, step_col};

    always_comb
    begin
        tag_issue.vld   = (state_reg == ST_ISSUE);
        tag_issue.first = (step_k == 2'd0);
        tag_issue.klast = (step_k == LAST_K);
        tag_issue.idx   = {step_row, step_col};
    end

    // The first half of the loads goes to the left matrix, the second half to
    // the right one. The final element's write lands before any read is issued,
    // so the memories need no forwarding.
    always_ff @(posedge clk)
    begin
        if (load_xfer && !load_count_reg[CNT_W-1]) begin
            a_mem[load_count_reg[IDX_W-1:0]] <= element_value[DATA_WIDTH-1:0];
        end
        a_q_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_xfer && load_count_reg[CNT_W-1]) begin
            b_mem[load_count_reg[IDX_W-1:0]] <= element_value[DATA_WIDTH-1:0];
        end
        b_q_reg <= b_mem[b_rd_addr];
    end

    // Sequencer: load 32 elements, issue 64 reads, then wait for the last result.
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        step_next       = step_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_xfer) begin
                    load_count_next = load_count_reg + CNT_W'(1);
                    if (load_count_reg == LAST_LOAD) begin
                        load_count_next = '0;
                        step_next       = '0;
                        state_next      = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_valid && (mac_idx == LAST_IDX)) begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            step_reg       <= '0;
            tag_s1_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            step_reg       <= step_next;
            tag_s1_reg     <= tag_issue;
        end
    end

    // Multiply, accumulate, and scale/saturate stages.
    mm4_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag_s1_reg),
        .a_data    (signed'(a_q_reg)),
        .b_data    (signed'(b_q_reg)),
        .res_valid (mac_valid),
        .res_value (mac_value),
        .res_idx   (mac_idx)
    );

    assign result_valid  = mac_valid;
    assign product_value = signed'(mac_value);
    assign row_index     = mac_idx[3:2];
    assign col_index     = mac_idx[1:0];
    assign last_result   = mac_valid && (mac_idx == LAST_IDX);

    // A result is only ever presented while a run is in progress.
    `MM4_ASSERT_SAME(a_result_in_run, result_valid, busy)
    // The transfer of the final element starts a run in the next cycle.
    `MM4_ASSERT_NEXT(a_run_starts, load_xfer && (load_count_reg == LAST_LOAD),
                     state_reg == ST_ISSUE)
    // After the last read the sequencer waits for the pipeline to drain.
    `MM4_ASSERT_NEXT(a_issue_ends, (state_reg == ST_ISSUE) && (step_reg == LAST_STEP),
                     state_reg == ST_DRAIN)
    // The load count never advances while the block is busy.
    `MM4_ASSERT_NEXT(a_count_holds, busy, $stable(load_count_reg) || (load_count_reg == '0))

endmodule
